// ===== hw/rtl/b2d_pkg.sv =====
// Shared types and constants for the binary to decimal ASCII field formatter.
// Used by the converter, the character emitter, the top level and the checker.
`timescale 1ns / 1ps

package b2d_pkg;

	// Input value width and the decimal digits needed to hold it
	localparam int VALUE_W   = 32;
	localparam int DIGITS    = 10;
	// Bits shifted into the BCD register per cycle
	localparam int STEP_BITS = 2;
	localparam int STEPS     = VALUE_W / STEP_BITS;
	localparam int STEP_CW   = $clog2(STEPS);

	// Character codes
	localparam int CHAR_W = 7;
	localparam logic [CHAR_W-1:0] CHAR_BLANK = 7'h20;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;

	// Word widths on the stream ports
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 8;
	localparam int FIELD_W_W  = 5;

	typedef logic [DIGITS-1:0][3:0] bcd_t;

	// Converter status toward the top level
	typedef struct packed {
		logic ready;
		logic done;
	} conv_st_t;

	// One formatting job handed to the emitter
	typedef struct packed {
		bcd_t bcd;
		logic neg;
		logic zf;
	} job_t;

endpackage

// ===== hw/rtl/b2d_conv.sv =====
// Bit-serial binary to BCD converter (shift and add-3), STEP_BITS bits a cycle.
// Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_conv (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [b2d_pkg::VALUE_W-1:0]      mag,
	input  logic                             take,
	output b2d_pkg::conv_st_t                st,
	output b2d_pkg::bcd_t                    bcd
);
	import b2d_pkg::*;

	typedef enum logic [2:0] {
		C_IDLE  = 3'b001,
		C_SHIFT = 3'b010,
		C_HOLD  = 3'b100
	} cstate_t;

	cstate_t              state_q;
	logic [STEP_CW-1:0]   cnt_q;
	logic [VALUE_W-1:0]   bin_q;
	bcd_t                 bcd_q;
	bcd_t                 bcd_nx;
	logic [VALUE_W-1:0]   bin_nx;

	// Adjust digits of five or more, then shift one bit in; twice per cycle
	always_comb begin
		bcd_nx = bcd_q;
		bin_nx = bin_q;
		for (int s = 0; s < STEP_BITS; s++) begin
			for (int d = 0; d < DIGITS; d++) begin
				if (bcd_nx[d] >= 4'd5) begin
					bcd_nx[d] = bcd_nx[d] + 4'd3;
				end
			end
			bcd_nx = bcd_t'({bcd_nx, bin_nx[VALUE_W-1]});
			bin_nx = {bin_nx[VALUE_W-2:0], 1'b0};
		end
	end

	// Sequence load, shift and hold until the emitter takes the digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_SHIFT;
						cnt_q   <= STEP_CW'(STEPS - 1);
					end
				end
				C_SHIFT: begin
					if (cnt_q == '0) begin
						state_q <= C_HOLD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				C_HOLD: begin
					if (take) begin
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (state_q == C_SHIFT) begin
			bin_q <= bin_nx;
			bcd_q <= bcd_nx;
		end
	end

	assign st.ready = (state_q == C_IDLE);
	assign st.done  = (state_q == C_HOLD);
	assign bcd      = bcd_q;

endmodule

// ===== hw/rtl/b2d_emit.sv =====
// Character emitter: walks field positions leftmost first and drives the
// output word register. Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_emit #(
	parameter int PCW = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  b2d_pkg::job_t                  job,
	input  logic [PCW-1:0]                 w,
	output logic                           idle,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [b2d_pkg::CHAR_W-1:0]     out_char,
	output logic                           out_last
);
	import b2d_pkg::*;

	typedef enum logic [2:0] {
		E_IDLE = 3'b001,
		E_FIND = 3'b010,
		E_RUN  = 3'b100
	} estate_t;

	estate_t            state_q;
	bcd_t               bcd_q;
	logic               neg_q;
	logic               zf_q;
	logic [PCW-1:0]     w_q;
	logic [PCW-1:0]     pos_q;
	logic [3:0]         msd_q;
	logic               noblank_q;
	logic               ovalid_q;
	logic [CHAR_W-1:0]  ochar_q;
	logic               olast_q;

	logic [3:0]         msd_c;
	logic [3:0]         digit;
	logic               blank;
	logic [CHAR_W-1:0]  chr;
	logic               adv;

	// Highest nonzero digit; zero when the value is zero
	always_comb begin
		msd_c = '0;
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[d] != 4'd0) begin
				msd_c = 4'(d);
			end
		end
	end

	// Character for the current position
	always_comb begin
		digit = (pos_q < PCW'(DIGITS)) ? bcd_q[pos_q[3:0]] : 4'd0;
		blank = (pos_q != '0) && !zf_q && (pos_q > PCW'(msd_q));
		if (neg_q && noblank_q && pos_q == w_q - 1'b1) begin
			chr = CHAR_MINUS;
		end else if (blank) begin
			chr = (neg_q && pos_q == PCW'(msd_q + 4'd1)) ? CHAR_MINUS : CHAR_BLANK;
		end else begin
			chr = CHAR_ZERO + CHAR_W'(digit);
		end
	end

	assign adv = (state_q == E_RUN) && (!ovalid_q || out_ready);

	// Control: capture job, find leading digit, step positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				E_IDLE: if (start) state_q <= E_FIND;
				E_FIND: state_q <= E_RUN;
				E_RUN: begin
					if (adv && pos_q == '0) begin
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
			if (adv) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && start) begin
			bcd_q <= job.bcd;
			neg_q <= job.neg;
			zf_q  <= job.zf;
			w_q   <= w;
			pos_q <= w - 1'b1;
		end
		if (state_q == E_FIND) begin
			msd_q     <= msd_c;
			noblank_q <= zf_q || (PCW'(msd_c) + 1'b1 >= w_q);
		end
		if (adv) begin
			ochar_q <= chr;
			olast_q <= (pos_q == '0);
			pos_q   <= pos_q - 1'b1;
		end
	end

	assign idle      = (state_q == E_IDLE);
	assign out_valid = ovalid_q;
	assign out_char  = ochar_q;
	assign out_last  = olast_q;

endmodule

// ===== hw/rtl/binary_to_decimal_ascii_field.sv =====
// Top level of the decimal ASCII field formatter: input stage, BCD converter
// and character emitter. Depends on b2d_pkg, b2d_conv and b2d_emit.
//
//  port group  dir  tdata bits (low first)                       side bits
//  s_*         in   value[31:0], width[36:32], zero_fill[37]     tuser = signed_mode
//  m_*         out  character[6:0], zero[7]                      tlast = last
//
// The converter shifts two value bits per cycle, then holds the digits until
// the emitter is free to take them. The emitter then finds the leading digit
// and sends one character per cycle while m_tready is high; conversion of the
// next value overlaps emission. s_tready is high while the converter is free.
// arst_n clears all control state; m_tvalid holds with a steady word while
// m_tready is low.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_field #(
	parameter int MAX_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [b2d_pkg::IN_DATA_W-1:0]     s_tdata,   // value, width, zero_fill
	input  logic                              s_tuser,   // signed_mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [b2d_pkg::OUT_DATA_W-1:0]    m_tdata,   // character, zero pad
	output logic                              m_tlast
);
	import b2d_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH + 1);
	localparam int PCW = (CW > FIELD_W_W) ? CW : FIELD_W_W;

	logic [VALUE_W-1:0]  value;
	logic [PCW-1:0]      width_x;
	logic [PCW-1:0]      wsat;
	logic                neg;
	logic                accept;
	logic                start_conv;
	logic [VALUE_W-1:0]  mag;
	conv_st_t            cst;
	bcd_t                bcd;
	logic                emit_idle;
	logic                handoff;
	job_t                job;
	logic                neg_q;
	logic                zf_q;
	logic [PCW-1:0]      w_q;
	logic [CHAR_W-1:0]   char_out;

	// Unpack, saturate the width and form the magnitude
	assign value      = s_tdata[VALUE_W-1:0];
	assign width_x    = PCW'(s_tdata[VALUE_W +: FIELD_W_W]);
	assign wsat       = (width_x > PCW'(MAX_WIDTH)) ? PCW'(MAX_WIDTH) : width_x;
	assign neg        = s_tuser && value[VALUE_W-1];
	assign mag        = neg ? (VALUE_W'(0) - value) : value;
	assign s_tready   = cst.ready;
	assign accept     = s_tvalid && s_tready;
	// Drop zero-width fields here
	assign start_conv = accept && (wsat != '0);

	// Hold formatting options while the value converts
	always_ff @(posedge clk) begin
		if (start_conv) begin
			neg_q <= neg;
			zf_q  <= s_tdata[VALUE_W + FIELD_W_W];
			w_q   <= wsat;
		end
	end

	b2d_conv u_conv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_conv),
		.mag    (mag),
		.take   (handoff),
		.st     (cst),
		.bcd    (bcd)
	);

	// Pass finished digits to the emitter when it is free
	assign handoff = cst.done && emit_idle;
	assign job.bcd = bcd;
	assign job.neg = neg_q;
	assign job.zf  = zf_q;

	b2d_emit #(
		.PCW (PCW)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (handoff),
		.job       (job),
		.w         (w_q),
		.idle      (emit_idle),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (char_out),
		.out_last  (m_tlast)
	);

	assign m_tdata = OUT_DATA_W'(char_out);

endmodule

// ===== hw/rtl/b2d_check.sv =====
// Port-level checker for the decimal ASCII field formatter, bound to the top.
// Depends on b2d_pkg.
`timescale 1ns / 1ps

module b2d_check #(
	parameter int MAX_WIDTH = 16
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [b2d_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic                              m_tlast
);
	import b2d_pkg::*;

	localparam int KW = $clog2(MAX_WIDTH + 1);

	logic [KW-1:0] count_q;
	logic          prev_digit_q;
	logic          out_word;
	logic          is_digit;
	logic          is_fill;

	assign out_word = m_tvalid && m_tready;
	assign is_digit = (m_tdata[CHAR_W-1:0] >= CHAR_ZERO) && (m_tdata[CHAR_W-1:0] <= CHAR_NINE);
	assign is_fill  = (m_tdata[CHAR_W-1:0] == CHAR_BLANK) || (m_tdata[CHAR_W-1:0] == CHAR_MINUS);

	// Track words in the current field and whether a digit came last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			prev_digit_q <= 1'b0;
		end else if (out_word) begin
			count_q      <= m_tlast ? '0 : count_q + 1'b1;
			prev_digit_q <= is_digit && !m_tlast;
		end
	end

	// Stalled word holds steady
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// Only digits, blank or minus, with the pad bit clear
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (is_digit || is_fill) && !m_tdata[OUT_DATA_W-1])
		else $error("illegal character code");

	// A field never runs past the widest field
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_word |-> (count_q < KW'(MAX_WIDTH - 1)) || m_tlast)
		else $error("field longer than MAX_WIDTH");

	// Right alignment: once digits start, no blank or minus follows
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_word && prev_digit_q |-> is_digit)
		else $error("fill character after a digit");

endmodule

bind binary_to_decimal_ascii_field b2d_check #(
	.MAX_WIDTH (MAX_WIDTH)
) u_b2d_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== tb/sv/binary_to_decimal_ascii_field_tb.sv =====
// Self-checking bench for the decimal ASCII field formatter: directed fields,
// then random ones, each character checked against typed-in text or a local field predictor.
// Depends on b2d_pkg and binary_to_decimal_ascii_field.
`timescale 1ns / 1ps

module binary_to_decimal_ascii_field_tb;

	import b2d_pkg::*;

	localparam int MAX_WIDTH    = 16;
	localparam int RANDOM_ITEMS = 206;
	localparam int QUIET_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 64;
	localparam int IDLE_PCT     = 14;

	// One field request; text holds the known field right-aligned, if any
	typedef struct packed {
		logic [31:0]            value;
		logic                   sgn;
		logic [FIELD_W_W-1:0]   wid;
		logic                   zf;
		logic                   known;
		logic [MAX_WIDTH*8-1:0] text;
	} field_req_t;

	// One expected output character
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} field_char_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // value[31:0], width[36:32], zero_fill[37]
	logic                  s_tuser;   // signed_mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;   // character[6:0], zero[7]
	logic                  m_tlast;

	field_char_t pending_chars[$];
	field_req_t  directed_fields[$];
	logic        calm = 1'b0;
	int          quiet_cycles = 0;
	int          mismatches = 0;
	int          chars_checked = 0;
	int          fields_sent = 0;

	binary_to_decimal_ascii_field #(
		.MAX_WIDTH(MAX_WIDTH)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Print one mismatch line (capped) and count it
	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 20)
			$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		mismatches++;
	endtask

	function automatic int clamp_width(input logic [FIELD_W_W-1:0] wid);
		return (wid > MAX_WIDTH) ? MAX_WIDTH : int'(wid);
	endfunction

	// Compute the field characters, rightmost first, and queue them leftmost first
	task automatic predict_field(input field_req_t req);
		logic [CHAR_W-1:0] chars [MAX_WIDTH];
		logic [31:0]       mag;
		logic              minus;
		int                w;
		int                idx;
		w = clamp_width(req.wid);
		minus = req.sgn && req.value[31];
		mag = minus ? (32'd0 - req.value) : req.value;
		for (int pos = 0; pos < w; pos++) begin
			idx = w - 1 - pos;
			if (mag == 0 && pos != 0 && !req.zf) begin
				chars[idx] = minus ? CHAR_MINUS : CHAR_BLANK;
				minus = 1'b0;
			end else begin
				chars[idx] = CHAR_ZERO + CHAR_W'(mag % 32'd10);
			end
			mag = mag / 32'd10;
		end
		// no blank left for the sign: overwrite the leftmost character
		if (minus)
			chars[0] = CHAR_MINUS;
		for (int k = 0; k < w; k++)
			pending_chars.push_back('{ch: chars[k], last: (k == w - 1)});
	endtask

	// Queue a field whose text is typed in
	task automatic queue_known_text(input field_req_t req);
		int w;
		w = clamp_width(req.wid);
		for (int k = 0; k < w; k++)
			pending_chars.push_back('{ch: req.text[(w-1-k)*8 +: CHAR_W], last: (k == w - 1)});
	endtask

	// Offer one word with random gaps, then queue its characters on acceptance
	task automatic send_field(input field_req_t req);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, req.zf, req.wid, req.value};
		s_tuser  <= req.sgn;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (req.known)
			queue_known_text(req);
		else
			predict_field(req);
		fields_sent++;
	endtask

	// Hold the sender until every queued character has come out
	task automatic drain_fields();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	function automatic field_req_t make_req(input logic [31:0] value, input logic sgn,
			input int wid, input logic zf, input logic known,
			input logic [MAX_WIDTH*8-1:0] text);
		return '{value: value, sgn: sgn, wid: FIELD_W_W'(wid), zf: zf, known: known,
			text: text};
	endfunction

	function automatic logic [31:0] random_value();
		logic [31:0] p;
		p = 32'd1;
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 99);
			1: return $urandom;
			2: return 32'd0 - $urandom_range(1, 1000);
			3: begin
				repeat ($urandom_range(0, 9)) p = p * 32'd10;
				return p + $urandom_range(0, 2) - 32'd1;
			end
			4: return 32'h8000_0000 ^ $urandom_range(0, 3);
			default: return $urandom_range(0, 99999);
		endcase
	endfunction

	function automatic field_req_t random_req();
		int r;
		int wid;
		r = $urandom_range(0, 99);
		if (r < 4)
			wid = 0;
		else if (r < 10)
			wid = $urandom_range(MAX_WIDTH + 1, 31);
		else
			wid = $urandom_range(1, MAX_WIDTH);
		return make_req(random_value(), 1'($urandom_range(0, 1)), wid,
			1'($urandom_range(0, 1)), 1'b0, '0);
	endfunction

	// Receiver: stall at random, except in the calm stretch
	always @(posedge clk)
		m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);

	// Check each accepted character against the oldest expectation
	always @(posedge clk) begin : check_word
		field_char_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				report_mismatch("unexpected character", m_tdata, 0);
			end else begin
				want = pending_chars.pop_front();
				if (m_tdata[CHAR_W-1:0] !== want.ch)
					report_mismatch("character", m_tdata[CHAR_W-1:0], want.ch);
				if (m_tlast !== want.last)
					report_mismatch("last flag", m_tlast, want.last);
			end
		end
	end

	// Count cycles with no word moving on either side
	always @(posedge clk)
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;

	initial begin : watchdog
		do
			@(posedge clk);
		while (quiet_cycles < QUIET_LIMIT);
		$display("timeout after %0d quiet cycles", quiet_cycles);
		$display("binary_to_decimal_ascii_field: mismatch");
		$finish;
	end

	initial begin : stimulus
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = 1'b0;

		// extremes, sign placement, truncation and width saturation
		directed_fields.push_back(make_req(32'd0, 0, 1, 0, 1, "0"));
		directed_fields.push_back(make_req(32'd0, 0, 5, 0, 1, "    0"));
		directed_fields.push_back(make_req(32'd0, 0, 5, 1, 1, "00000"));
		directed_fields.push_back(make_req(32'd42, 0, 5, 0, 1, "   42"));
		directed_fields.push_back(make_req(32'hFFFF_FFFF, 0, 16, 0, 1, "      4294967295"));
		directed_fields.push_back(make_req(32'hFFFF_FFFF, 0, 10, 1, 1, "4294967295"));
		directed_fields.push_back(make_req(32'hFFFF_FFFF, 0, 4, 0, 1, "7295"));
		directed_fields.push_back(make_req(32'hFFFF_FFFF, 1, 5, 0, 1, "   -1"));
		directed_fields.push_back(make_req(32'h8000_0000, 1, 16, 0, 1, "     -2147483648"));
		directed_fields.push_back(make_req(32'h8000_0000, 1, 10, 0, 1, "-147483648"));
		directed_fields.push_back(make_req(32'd0 - 32'd42, 1, 6, 1, 1, "-00042"));
		directed_fields.push_back(make_req(32'd0 - 32'd5, 1, 1, 0, 1, "-"));
		directed_fields.push_back(make_req(32'd77, 0, 0, 0, 1, ""));
		directed_fields.push_back(make_req(32'd123, 0, 31, 0, 1, "             123"));
		directed_fields.push_back(make_req(32'd7, 0, 17, 1, 1, "0000000000000007"));
		directed_fields.push_back(make_req(32'h7FFF_FFFF, 1, 12, 0, 1, "  2147483647"));
		directed_fields.push_back(make_req(32'd1234567890, 0, 1, 0, 1, "0"));
		directed_fields.push_back(make_req(32'd0 - 32'd123, 1, 3, 0, 1, "-23"));
		directed_fields.push_back(make_req(32'd0, 1, 3, 0, 1, "  0"));
		directed_fields.push_back(make_req(32'd0 - 32'd7, 1, 2, 0, 1, "-7"));
		directed_fields.push_back(make_req(32'd0 - 32'd9, 1, 16, 1, 1, "-000000000000009"));
		directed_fields.push_back(make_req(32'd1000000000, 0, 16, 1, 0, '0));
		directed_fields.push_back(make_req(32'd305419896, 0, 8, 0, 0, '0));
		directed_fields.push_back(make_req(32'hFFFF_FF00, 1, 20, 0, 0, '0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_fields[i])
			send_field(directed_fields[i]);
		drain_fields();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 100)
				drain_fields();
			if (n == 150)
				calm <= 1'b1;
			if (n == 190)
				calm <= 1'b0;
			send_field(random_req());
		end
		s_tvalid <= 1'b0;

		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0)
			report_mismatch("characters never received", 0, pending_chars.size());

		$display("%0d fields sent (%0d directed), %0d characters checked", fields_sent,
			directed_fields.size(), chars_checked);
		$display("covered widths 0 to 31, signed and unsigned, blank and zero fill");
		if (mismatches == 0)
			$display("binary_to_decimal_ascii_field: match");
		else
			$display("binary_to_decimal_ascii_field: mismatch");
		$finish;
	end

endmodule
